// ===== design/vnorm_pkg.sv =====
// ----------------------------------------------------------------------------
// vnorm_pkg
// Shared constants for the four-component vector normalizer.
// ----------------------------------------------------------------------------
package vnorm_pkg;

    localparam int COMP_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 13;
    localparam int N_LANES        = 4;

endpackage

// ===== design/vnorm_if.sv =====
// ----------------------------------------------------------------------------
// vnorm_in_if / vnorm_out_if
// Valid/ready channels carrying input vectors and normalized results.
// ----------------------------------------------------------------------------
interface vnorm_in_if #(
    parameter int CW = vnorm_pkg::COMP_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] comp_x;
    logic signed [CW-1:0] comp_y;
    logic signed [CW-1:0] comp_z;
    logic signed [CW-1:0] comp_w;

    modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
    modport sink   (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

interface vnorm_out_if #(
    parameter int CW = vnorm_pkg::COMP_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] norm_x;
    logic signed [CW-1:0] norm_y;
    logic signed [CW-1:0] norm_z;
    logic signed [CW-1:0] norm_w;
    logic                 passed_unchanged;

    modport source (output valid, norm_x, norm_y, norm_z, norm_w, passed_unchanged,
                    input ready);
    modport sink   (input valid, norm_x, norm_y, norm_z, norm_w, passed_unchanged,
                    output ready);
endinterface

// ===== design/vnorm_step.sv =====
// ----------------------------------------------------------------------------
// vnorm_step
// One restoring step of the scaled quotient search: tries bit BIT of each
// lane's quotient q, keeping q^2*S and q*S as running sums.
// ----------------------------------------------------------------------------
module vnorm_step #(
    parameter int CW  = vnorm_pkg::COMP_WIDTH_DEF,
    parameter int F   = vnorm_pkg::FRAC_BITS_DEF,
    parameter int BIT = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [2*CW:0]       i_s,
    input  logic [2*CW+2*F+2:0] i_t    [vnorm_pkg::N_LANES],
    input  logic [2*CW+2*F+2:0] i_p    [vnorm_pkg::N_LANES],
    input  logic [2*CW+F+1:0]   i_qs   [vnorm_pkg::N_LANES],
    input  logic [F:0]          i_q    [vnorm_pkg::N_LANES],
    input  logic [CW-1:0]       i_comp [vnorm_pkg::N_LANES],
    input  logic                i_pass,
    output logic                o_valid,
    output logic [2*CW:0]       o_s,
    output logic [2*CW+2*F+2:0] o_t    [vnorm_pkg::N_LANES],
    output logic [2*CW+2*F+2:0] o_p    [vnorm_pkg::N_LANES],
    output logic [2*CW+F+1:0]   o_qs   [vnorm_pkg::N_LANES],
    output logic [F:0]          o_q    [vnorm_pkg::N_LANES],
    output logic [CW-1:0]       o_comp [vnorm_pkg::N_LANES],
    output logic                o_pass
);
    import vnorm_pkg::*;

    localparam int SW = 2*CW + 1;
    localparam int PW = 2*CW + 2*F + 3;
    localparam int QW = SW + F + 1;

    logic          r_valid;
    logic [SW-1:0] r_s;
    logic [PW-1:0] r_t    [N_LANES];
    logic [PW-1:0] r_p    [N_LANES];
    logic [QW-1:0] r_qs   [N_LANES];
    logic [F:0]    r_q    [N_LANES];
    logic [CW-1:0] r_comp [N_LANES];
    logic          r_pass;

    logic [PW-1:0] n_p    [N_LANES];
    logic [QW-1:0] n_qs   [N_LANES];
    logic [F:0]    n_q    [N_LANES];
    logic [PW-1:0] cand   [N_LANES];

    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            cand[l] = i_p[l] + (PW'(i_qs[l]) << (BIT + 1)) + (PW'(i_s) << (2*BIT));
            if (cand[l] <= i_t[l]) begin
                n_p[l]  = cand[l];
                n_qs[l] = i_qs[l] + (QW'(i_s) << BIT);
                n_q[l]  = i_q[l] | ((F+1)'(1) << BIT);
            end else begin
                n_p[l]  = i_p[l];
                n_qs[l] = i_qs[l];
                n_q[l]  = i_q[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s    <= i_s;
            r_t    <= i_t;
            r_p    <= n_p;
            r_qs   <= n_qs;
            r_q    <= n_q;
            r_comp <= i_comp;
            r_pass <= i_pass;
        end
    end

    assign o_valid = r_valid;
    assign o_s     = r_s;
    assign o_t     = r_t;
    assign o_p     = r_p;
    assign o_qs    = r_qs;
    assign o_q     = r_q;
    assign o_comp  = r_comp;
    assign o_pass  = r_pass;

endmodule

// ===== design/vec4_normalize.sv =====
// ----------------------------------------------------------------------------
// vec4_normalize
// Scales a four-component signed fixed-point vector to unit length,
// truncating each component toward zero; zero and unit vectors pass through.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  i_vec    in   valid/ready    comp_x, comp_y, comp_z, comp_w
//  o_vec    out  valid/ready    norm_x, norm_y, norm_z, norm_w, passed_unchanged
//
//  One vector per cycle while o_vec.ready is high; stages: squares, sum,
//  FRAC_BITS+1 quotient steps (one bit per stage), output register.
//  Each stage holds when its successor is full and stalled, so bubbles close up.
//  Reset (synchronous) clears the valid bits only.
// ----------------------------------------------------------------------------
module vec4_normalize #(
    parameter int COMP_WIDTH = vnorm_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = vnorm_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vnorm_in_if.sink      i_vec,
    vnorm_out_if.source   o_vec
);
    import vnorm_pkg::*;

    localparam int CW = COMP_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int SW = 2*CW + 1;
    localparam int PW = 2*CW + 2*F + 3;
    localparam int QW = SW + F + 1;
    localparam int NS = F + 1;
    localparam int NSTG = NS + 3;
    localparam int MW = ((F + 1 > CW) ? F + 1 : CW) + 1;

    logic [NSTG-1:0] en;
    logic [NSTG-1:0] vld;

    // stage A: magnitudes squared
    logic            r_a_valid;
    logic [2*CW-1:0] r_a_sq   [N_LANES];
    logic [CW-1:0]   r_a_comp [N_LANES];
    logic [CW-1:0]   in_comp  [N_LANES];
    logic [CW-1:0]   a_mag    [N_LANES];
    logic [2*CW-1:0] n_a_sq   [N_LANES];

    // stage B: sum of squares, targets
    logic          r_b_valid;
    logic [SW-1:0] r_b_s;
    logic [PW-1:0] r_b_t    [N_LANES];
    logic [CW-1:0] r_b_comp [N_LANES];
    logic          r_b_pass;
    logic [SW-1:0] n_b_s;

    logic [NS:0]   pv;
    logic [SW-1:0] ps     [NS+1];
    logic [PW-1:0] pt     [NS+1][N_LANES];
    logic [PW-1:0] pp     [NS+1][N_LANES];
    logic [QW-1:0] pqs    [NS+1][N_LANES];
    logic [F:0]    pq     [NS+1][N_LANES];
    logic [CW-1:0] pcomp  [NS+1][N_LANES];
    logic          ppass  [NS+1];

    // output stage
    logic          r_o_valid;
    logic [CW-1:0] r_o_norm [N_LANES];
    logic          r_o_pass;
    logic [CW-1:0] n_o_norm [N_LANES];
    logic [MW-1:0] qe       [N_LANES];
    logic [MW-1:0] qlim     [N_LANES];

    assign in_comp[0] = i_vec.comp_x;
    assign in_comp[1] = i_vec.comp_y;
    assign in_comp[2] = i_vec.comp_z;
    assign in_comp[3] = i_vec.comp_w;

    assign vld[0] = r_a_valid;
    assign vld[1] = r_b_valid;
    assign vld[NSTG-1] = r_o_valid;
    for (genvar k = 0; k < NS; k++) begin : g_vld
        assign vld[k+2] = pv[k+1];
    end

    always_comb begin
        en[NSTG-1] = !vld[NSTG-1] || o_vec.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !vld[k] || en[k+1];
        end
    end

    assign i_vec.ready = en[0];

    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            a_mag[l]  = in_comp[l][CW-1] ? (~in_comp[l] + CW'(1)) : in_comp[l];
            n_a_sq[l] = (2*CW)'(a_mag[l]) * (2*CW)'(a_mag[l]);
        end
    end

    always_comb begin
        n_b_s = '0;
        for (int l = 0; l < N_LANES; l++) begin
            n_b_s = n_b_s + SW'(r_a_sq[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en[0]) begin
                r_a_valid <= i_vec.valid;
            end
            if (en[1]) begin
                r_b_valid <= r_a_valid;
            end
            if (en[NSTG-1]) begin
                r_o_valid <= pv[NS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_a_sq   <= n_a_sq;
            r_a_comp <= in_comp;
        end
        if (en[1]) begin
            r_b_s    <= n_b_s;
            r_b_comp <= r_a_comp;
            r_b_pass <= (n_b_s == '0) || (PW'(n_b_s) == (PW'(1) << (2*F)));
            for (int l = 0; l < N_LANES; l++) begin
                r_b_t[l] <= PW'(r_a_sq[l]) << (2*F);
            end
        end
    end

    assign pv[0]    = r_b_valid;
    assign ps[0]    = r_b_s;
    assign pt[0]    = r_b_t;
    assign pcomp[0] = r_b_comp;
    assign ppass[0] = r_b_pass;
    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            pp[0][l]  = '0;
            pqs[0][l] = '0;
            pq[0][l]  = '0;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_step
        vnorm_step #(
            .CW  (CW),
            .F   (F),
            .BIT (F - k)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en[k+2]),
            .i_valid (pv[k]),
            .i_s     (ps[k]),
            .i_t     (pt[k]),
            .i_p     (pp[k]),
            .i_qs    (pqs[k]),
            .i_q     (pq[k]),
            .i_comp  (pcomp[k]),
            .i_pass  (ppass[k]),
            .o_valid (pv[k+1]),
            .o_s     (ps[k+1]),
            .o_t     (pt[k+1]),
            .o_p     (pp[k+1]),
            .o_qs    (pqs[k+1]),
            .o_q     (pq[k+1]),
            .o_comp  (pcomp[k+1]),
            .o_pass  (ppass[k+1])
        );
    end

    // sign and saturate, or pass the component through
    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            qe[l] = MW'(pq[NS][l]);
            if (pcomp[NS][l][CW-1]) begin
                qlim[l] = MW'(1) << (CW - 1);
            end else begin
                qlim[l] = (MW'(1) << (CW - 1)) - MW'(1);
            end
            if (qe[l] > qlim[l]) begin
                qe[l] = qlim[l];
            end
            if (ppass[NS]) begin
                n_o_norm[l] = pcomp[NS][l];
            end else if (pcomp[NS][l][CW-1]) begin
                n_o_norm[l] = CW'(~qe[l] + MW'(1));
            end else begin
                n_o_norm[l] = CW'(qe[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NSTG-1]) begin
            r_o_norm <= n_o_norm;
            r_o_pass <= ppass[NS];
        end
    end

    assign o_vec.valid            = r_o_valid;
    assign o_vec.norm_x           = r_o_norm[0];
    assign o_vec.norm_y           = r_o_norm[1];
    assign o_vec.norm_z           = r_o_norm[2];
    assign o_vec.norm_w           = r_o_norm[3];
    assign o_vec.passed_unchanged = r_o_pass;

`ifndef SYNTH
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_vec.valid)
        else $error("output valid after reset");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vec.valid && i_vec.ready |=> r_a_valid)
        else $error("accepted transfer lost at first stage");

    a_zero_sum_zero_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b_s == '0 |->
        r_b_comp[0] == '0 && r_b_comp[1] == '0 && r_b_comp[2] == '0
        && r_b_comp[3] == '0)
        else $error("zero sum of squares with nonzero component");

    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pv[NS] && !ppass[NS] |->
        !((pq[NS][0][F] && |pq[NS][0][F-1:0]) || (pq[NS][1][F] && |pq[NS][1][F-1:0])
        || (pq[NS][2][F] && |pq[NS][2][F-1:0]) || (pq[NS][3][F] && |pq[NS][3][F-1:0])))
        else $error("quotient above unity");

    a_stall_holds_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pv[NS] && r_o_valid && !o_vec.ready |=> pv[NS])
        else $error("last quotient stage dropped during stall");
`endif

endmodule
